@@ rtl/core/scm_pkg.sv @@
package scm_pkg;

  localparam int VALUE_WIDTH     = 32;
  localparam int PALETTE_ENTRIES = 7;
  localparam int FRAC_BITS       = 20;
  localparam int POLY_W          = 50;
  localparam int POLY_SHIFT      = 2 * FRAC_BITS + 4;

  localparam logic [1:0] SCHEME_RAMP    = 2'd0;
  localparam logic [1:0] SCHEME_POLY    = 2'd1;
  localparam logic [1:0] SCHEME_PALETTE = 2'd2;

  localparam logic [1:0] REG_SCHEME = 2'd0;
  localparam logic [1:0] REG_MIN    = 2'd1;
  localparam logic [1:0] REG_MAX    = 2'd2;

  localparam logic [1:0] COMP_RED   = 2'd0;
  localparam logic [1:0] COMP_GREEN = 2'd1;

  // Per-item data that rides alongside the interpolation divider.
  typedef struct packed {
    logic                   nan;
    logic                   inv;
    logic [2:0][7:0]        ramp;
    logic [2:0][POLY_W-1:0] poly;
    logic [2:0][7:0]        base;
    logic [2:0]             up;
  } back_side_t;

  function automatic logic [7:0] pal_entry(input logic [1:0] comp, input logic [3:0] idx);
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    unique case (idx)
      4'd0:    begin r = 8'd252; g = 8'd0;   b = 8'd26;  end
      4'd1:    begin r = 8'd254; g = 8'd173; b = 8'd41;  end
      4'd2:    begin r = 8'd252; g = 8'd245; b = 8'd52;  end
      4'd3:    begin r = 8'd25;  g = 8'd225; b = 8'd39;  end
      4'd4:    begin r = 8'd22;  g = 8'd166; b = 8'd252; end
      4'd5:    begin r = 8'd5;   g = 8'd12;  b = 8'd193; end
      4'd6:    begin r = 8'd179; g = 8'd15;  b = 8'd248; end
      default: begin r = 8'd0;   g = 8'd0;   b = 8'd0;   end
    endcase
    if (comp == COMP_RED) return r;
    else if (comp == COMP_GREEN) return g;
    else return b;
  endfunction

  // floor(255 * num / 2^POLY_SHIFT) for a signed polynomial value, cut at 0 and 255.
  function automatic logic [7:0] poly_component(input logic [POLY_W-1:0] num);
    logic [POLY_W+7:0] prod;
    logic [7:0]        res;
    prod = (POLY_W + 8)'(num) * (POLY_W + 8)'(255);
    if (num[POLY_W-1] || num == '0) res = '0;
    else if (|prod[POLY_W+7:POLY_SHIFT+8]) res = 8'hFF;
    else res = prod[POLY_SHIFT+7:POLY_SHIFT];
    return res;
  endfunction

endpackage

@@ rtl/core/scalar_to_color_map_core.sv @@
// Scalar to color map: one sample in, one RGB result out, in a fixed pipeline.
// The pipeline has three front stages, a 21-stage quotient divider, two mixing stages,
// an 8-stage interpolation divider and the output register. Throughput is one sample
// per cycle; the pipeline holds as a whole while the output register is full and not taken.
// Reset is synchronous: it clears all valid bits and loads the default registers.
module scalar_to_color_map_core #(
  parameter int VALUE_WIDTH     = scm_pkg::VALUE_WIDTH,
  parameter int PALETTE_ENTRIES = scm_pkg::PALETTE_ENTRIES
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // sample_value, then zero fill to whole bytes
  input  logic [((VALUE_WIDTH + 7) / 8) * 8-1:0] s_axis_tdata,
  // sample_not_number
  input  logic                                 s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // red [7:0], green [15:8], blue [23:16]
  output logic [23:0]                          m_axis_tdata,
  // range_invalid
  output logic                                 m_axis_tuser,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [1:0]                           cfg_index,
  input  logic [VALUE_WIDTH-1:0]               cfg_data
);

  localparam int VW     = VALUE_WIDTH;
  localparam int DW     = (VW > 32) ? 32 : VW;
  localparam int QA_W   = scm_pkg::FRAC_BITS + 1;
  localparam int NA_W   = DW + scm_pkg::FRAC_BITS;
  localparam int NL_W   = DW + 8;
  localparam int SIDE_W = $bits(scm_pkg::back_side_t);

  logic [1:0]    scheme_sel;
  logic [VW-1:0] range_min;
  logic [VW-1:0] range_max;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      scheme_sel <= scm_pkg::SCHEME_RAMP;
      range_min  <= '0;
      range_max  <= VW'(65536);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        scm_pkg::REG_SCHEME: scheme_sel <= cfg_data[1:0];
        scm_pkg::REG_MIN:    range_min  <= cfg_data;
        scm_pkg::REG_MAX:    range_max  <= cfg_data;
        default: ;
      endcase
    end
  end

  logic ce;
  logic out_v;
  assign ce            = !out_v || m_axis_tready;
  assign s_axis_tready = ce;

  // Stage 0: input register.
  logic          s0_v;
  logic [VW-1:0] s0_sample;
  logic          s0_nan;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_v <= 1'b0;
    end else if (ce) begin
      s0_v <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      s0_sample <= s_axis_tdata[VW-1:0];
      s0_nan    <= s_axis_tuser;
    end
  end

  // Stage 1: clamp and position in an order-preserving unsigned key space.
  logic [VW-1:0] sign_flip;
  logic [VW-1:0] kv;
  logic [VW-1:0] kmin;
  logic [VW-1:0] kmax;
  logic [VW-1:0] kc;
  logic [VW-1:0] d_full;
  logic [VW-1:0] pos_full;
  logic [DW-1:0] d_norm;
  logic [DW-1:0] pos_norm;
  logic          invalid;

  always_comb begin
    sign_flip = {1'b1, {(VW - 1){1'b0}}};
    kv        = s0_sample ^ sign_flip;
    kmin      = range_min ^ sign_flip;
    kmax      = range_max ^ sign_flip;
    invalid   = (kmax <= kmin);
    if (kv < kmin) kc = kmin;
    else if (kv > kmax) kc = kmax;
    else kc = kv;
    d_full   = kmax - kmin;
    pos_full = kc - kmin;
  end

  if (VW > DW) begin : g_norm
    localparam int SH_W = $clog2(VW - DW + 1);
    logic [SH_W-1:0] sh;
    always_comb begin
      sh = '0;
      for (int i = DW; i < VW; i++) begin
        if (d_full[i]) sh = SH_W'(i - DW + 1);
      end
    end
    assign d_norm   = DW'(d_full >> sh);
    assign pos_norm = DW'(pos_full >> sh);
  end else begin : g_direct
    assign d_norm   = d_full;
    assign pos_norm = pos_full;
  end

  logic          s1_v;
  logic          s1_nan;
  logic          s1_inv;
  logic [DW-1:0] s1_pos;
  logic [DW-1:0] s1_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (ce) begin
      s1_v <= s0_v;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      s1_nan <= s0_nan;
      s1_inv <= invalid;
      s1_pos <= pos_norm;
      s1_d   <= d_norm;
    end
  end

  // Stage 2: dividends for the three quotient lanes.
  logic [2:0][NA_W-1:0] num_next;

  always_comb begin
    logic [DW:0] twice;
    logic [DW:0] mid_gap;
    twice   = {s1_pos, 1'b0};
    mid_gap = (twice >= {1'b0, s1_d}) ? twice - {1'b0, s1_d} : {1'b0, s1_d} - twice;
    unique case (scheme_sel)
      scm_pkg::SCHEME_RAMP: num_next[0] = NA_W'(s1_pos) * NA_W'(510);
      scm_pkg::SCHEME_POLY: num_next[0] = NA_W'(s1_pos) << scm_pkg::FRAC_BITS;
      default:              num_next[0] = NA_W'(s1_pos) * NA_W'(PALETTE_ENTRIES);
    endcase
    num_next[1] = NA_W'(s1_d - mid_gap[DW-1:0]) * NA_W'(255);
    num_next[2] = NA_W'(s1_d - s1_pos) * NA_W'(510);
  end

  logic                 s2_v;
  logic                 s2_nan;
  logic                 s2_inv;
  logic [DW-1:0]        s2_pos;
  logic [DW-1:0]        s2_d;
  logic [2:0][NA_W-1:0] s2_num;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (ce) begin
      s2_v <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      s2_nan <= s1_nan;
      s2_inv <= s1_inv;
      s2_pos <= s1_pos;
      s2_d   <= s1_d;
      s2_num <= num_next;
    end
  end

  logic                 d1_v;
  logic [2:0][QA_W-1:0] d1_quo;
  logic [DW-1:0]        d1_den;
  logic [DW+1:0]        d1_side;

  scm_div #(
    .NUM_W  (NA_W),
    .DEN_W  (DW),
    .Q_W    (QA_W),
    .SIDE_W (DW + 2)
  ) u_div_quot (
    .clk       (clk),
    .rst       (rst),
    .en        (ce),
    .in_valid  (s2_v),
    .num       (s2_num),
    .den       (s2_d),
    .in_side   ({s2_nan, s2_inv, s2_pos}),
    .out_valid (d1_v),
    .quo       (d1_quo),
    .out_den   (d1_den),
    .out_side  (d1_side)
  );

  logic                 bk_v;
  scm_pkg::back_side_t  bk_side;
  logic [2:0][NL_W-1:0] bk_num;
  logic [DW-1:0]        bk_den;

  scm_back #(
    .DW              (DW),
    .QA_W            (QA_W),
    .PALETTE_ENTRIES (PALETTE_ENTRIES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .en        (ce),
    .in_valid  (d1_v),
    .quo       (d1_quo),
    .nan       (d1_side[DW+1]),
    .inv       (d1_side[DW]),
    .pos       (d1_side[DW-1:0]),
    .den       (d1_den),
    .out_valid (bk_v),
    .out_side  (bk_side),
    .lerp_num  (bk_num),
    .out_den   (bk_den)
  );

  logic              d2_v;
  logic [2:0][7:0]   d2_quo;
  logic [SIDE_W-1:0] d2_side;

  scm_div #(
    .NUM_W  (NL_W),
    .DEN_W  (DW),
    .Q_W    (8),
    .SIDE_W (SIDE_W)
  ) u_div_lerp (
    .clk       (clk),
    .rst       (rst),
    .en        (ce),
    .in_valid  (bk_v),
    .num       (bk_num),
    .den       (bk_den),
    .in_side   (bk_side),
    .out_valid (d2_v),
    .quo       (d2_quo),
    .out_den   (),
    .out_side  (d2_side)
  );

  // Final selection into the output register.
  scm_pkg::back_side_t fin;
  logic [2:0][7:0]     color;

  assign fin = d2_side;

  always_comb begin
    logic [8:0] sum;
    logic [7:0] lerp;
    for (int l = 0; l < 3; l++) begin
      sum = {1'b0, fin.base[l]} + {1'b0, d2_quo[l]};
      if (fin.up[l]) lerp = sum[8] ? 8'hFF : sum[7:0];
      else lerp = (d2_quo[l] > fin.base[l]) ? 8'h00 : fin.base[l] - d2_quo[l];
      if (fin.nan) begin
        color[l] = (l == 1) ? 8'h00 : 8'hFF;
      end else if (fin.inv) begin
        color[l] = 8'h00;
      end else begin
        unique case (scheme_sel)
          scm_pkg::SCHEME_RAMP: color[l] = fin.ramp[l];
          scm_pkg::SCHEME_POLY: color[l] = scm_pkg::poly_component(fin.poly[l]);
          default:              color[l] = lerp;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (ce) begin
      out_v <= d2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      m_axis_tdata <= {color[2], color[1], color[0]};
      m_axis_tuser <= fin.inv;
    end
  end

  assign m_axis_tvalid = out_v;

endmodule

@@ rtl/core/scm_div.sv @@
module scm_div #(
  parameter int NUM_W  = 52,
  parameter int DEN_W  = 32,
  parameter int Q_W    = 21,
  parameter int SIDE_W = 1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_valid,
  input  logic [2:0][NUM_W-1:0]  num,
  input  logic [DEN_W-1:0]       den,
  input  logic [SIDE_W-1:0]      in_side,
  output logic                   out_valid,
  output logic [2:0][Q_W-1:0]    quo,
  output logic [DEN_W-1:0]       out_den,
  output logic [SIDE_W-1:0]      out_side
);

  localparam int W = DEN_W + Q_W;

  // One quotient bit per stage, most significant first; the three lanes share the divisor.
  logic                  vld  [0:Q_W-1];
  logic [2:0][W-1:0]     rem  [0:Q_W-1];
  logic [2:0][Q_W-1:0]   qs   [0:Q_W-1];
  logic [DEN_W-1:0]      dens [0:Q_W-1];
  logic [SIDE_W-1:0]     side [0:Q_W-1];

  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    logic                vin;
    logic [2:0][W-1:0]   rin;
    logic [2:0][Q_W-1:0] qin;
    logic [DEN_W-1:0]    din;
    logic [SIDE_W-1:0]   sin;
    logic [2:0][W-1:0]   rnext;
    logic [2:0][Q_W-1:0] qnext;

    if (k == 0) begin : g_first
      assign vin = in_valid;
      assign rin = {W'(num[2]), W'(num[1]), W'(num[0])};
      assign qin = '0;
      assign din = den;
      assign sin = in_side;
    end else begin : g_next
      assign vin = vld[k-1];
      assign rin = rem[k-1];
      assign qin = qs[k-1];
      assign din = dens[k-1];
      assign sin = side[k-1];
    end

    always_comb begin
      logic [W:0] trial;
      for (int l = 0; l < 3; l++) begin
        trial = {1'b0, rin[l]} - {1'b0, (W'(din) << (Q_W - 1 - k))};
        qnext[l] = qin[l];
        if (trial[W]) begin
          rnext[l] = rin[l];
        end else begin
          rnext[l] = trial[W-1:0];
          qnext[l][Q_W-1-k] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= vin;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k]  <= rnext;
        qs[k]   <= qnext;
        dens[k] <= din;
        side[k] <= sin;
      end
    end
  end

  assign out_valid = vld[Q_W-1];
  assign quo       = qs[Q_W-1];
  assign out_den   = dens[Q_W-1];
  assign out_side  = side[Q_W-1];

endmodule

@@ rtl/core/scm_back.sv @@
module scm_back #(
  parameter int DW              = 32,
  parameter int QA_W            = 21,
  parameter int PALETTE_ENTRIES = 7
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    in_valid,
  input  logic [2:0][QA_W-1:0]    quo,
  input  logic                    nan,
  input  logic                    inv,
  input  logic [DW-1:0]           pos,
  input  logic [DW-1:0]           den,
  output logic                    out_valid,
  output scm_pkg::back_side_t     out_side,
  output logic [2:0][DW+7:0]      lerp_num,
  output logic [DW-1:0]           out_den
);

  localparam int SEG_W = $clog2(PALETTE_ENTRIES);
  localparam int MW    = DW + 5;
  localparam int PW    = scm_pkg::POLY_W;
  localparam int NL_W  = DW + 8;

  logic [SEG_W-1:0] seg;
  logic [MW-1:0]    span_pos;
  logic [2:0][7:0]  ramp;

  always_comb begin
    if (quo[0] >= QA_W'(PALETTE_ENTRIES - 1)) seg = SEG_W'(PALETTE_ENTRIES - 1);
    else seg = quo[0][SEG_W-1:0];
    span_pos = MW'(pos) * MW'(PALETTE_ENTRIES) - MW'(seg) * MW'(den);
    ramp[0]  = (quo[0] > QA_W'(255)) ? 8'hFF : quo[0][7:0];
    ramp[1]  = quo[1][7:0];
    ramp[2]  = (quo[2] > QA_W'(255)) ? 8'hFF : quo[2][7:0];
  end

  logic                m1_v;
  logic                m1_nan;
  logic                m1_inv;
  logic [QA_W-1:0]     m1_n;
  logic [2*QA_W-1:0]   m1_n2;
  logic [SEG_W-1:0]    m1_seg;
  logic [DW-1:0]       m1_num;
  logic [DW-1:0]       m1_den;
  logic [2:0][7:0]     m1_ramp;

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_v <= 1'b0;
    end else if (en) begin
      m1_v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_nan  <= nan;
      m1_inv  <= inv;
      m1_n    <= quo[0];
      m1_n2   <= (2 * QA_W)'(quo[0]) * (2 * QA_W)'(quo[0]);
      m1_seg  <= seg;
      m1_num  <= span_pos[DW-1:0];
      m1_den  <= den;
      m1_ramp <= ramp;
    end
  end

  scm_pkg::back_side_t side_next;
  logic [2:0][NL_W-1:0] nl_next;

  always_comb begin
    logic [PW-1:0]    n2w;
    logic [PW-1:0]    nsh;
    logic [SEG_W-1:0] seg1;
    logic [3:0]       ia;
    logic [3:0]       ib;
    logic [7:0]       a;
    logic [7:0]       b;
    logic [7:0]       diff;
    logic [NL_W-1:0]  prod;
    n2w = PW'(m1_n2);
    nsh = PW'(m1_n) << scm_pkg::FRAC_BITS;
    side_next.nan  = m1_nan;
    side_next.inv  = m1_inv;
    side_next.ramp = m1_ramp;
    side_next.poly[0] = nsh * PW'(120) - n2w * PW'(80)
                        - (PW'(29) << (2 * scm_pkg::FRAC_BITS));
    side_next.poly[1] = nsh * PW'(320) - n2w * PW'(320)
                        - (PW'(64) << (2 * scm_pkg::FRAC_BITS));
    side_next.poly[2] = nsh * PW'(40) - n2w * PW'(80)
                        + (PW'(11) << (2 * scm_pkg::FRAC_BITS));
    if (m1_seg >= SEG_W'(PALETTE_ENTRIES - 1)) seg1 = SEG_W'(PALETTE_ENTRIES - 1);
    else seg1 = m1_seg + SEG_W'(1);
    // The palette is walked from its last entry toward its first.
    ia = 4'(PALETTE_ENTRIES - 1) - 4'(m1_seg);
    ib = 4'(PALETTE_ENTRIES - 1) - 4'(seg1);
    for (int l = 0; l < 3; l++) begin
      a    = scm_pkg::pal_entry(2'(l), ia);
      b    = scm_pkg::pal_entry(2'(l), ib);
      diff = (b >= a) ? b - a : a - b;
      prod = NL_W'(diff) * NL_W'(m1_num);
      side_next.base[l] = a;
      side_next.up[l]   = (b >= a);
      // A falling segment rounds its step up so that a - step is the floor.
      if (b >= a) nl_next[l] = prod;
      else nl_next[l] = prod + NL_W'(m1_den) - NL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= m1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_side <= side_next;
      lerp_num <= nl_next;
      out_den  <= m1_den;
    end
  end

endmodule

@@ tb/scalar_to_color_map_core_test.sv @@
`timescale 1ns / 100ps

module scalar_to_color_map_core_test;

  typedef struct packed {
    logic [31:0] value;
    logic        not_number;
  } sample_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       invalid;
  } color_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic m_axis_tuser;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  sample_t pending_samples[$];
  color_t expected_colors[$];
  logic [1:0] model_scheme;
  logic [31:0] model_min;
  logic [31:0] model_max;
  int send_idle_pct;
  int recv_idle_pct;
  bit hold_off;
  int errors;
  int quiet_cycles;

  scalar_to_color_map_core i_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [7:0] sat8(input longint unsigned v);
    return (v > 255) ? 8'd255 : v[7:0];
  endfunction

  function automatic logic [7:0] quad_component(input longint num);
    if (num <= 0) return 8'd0;
    return sat8((longint'(num) * 255) >>> scm_pkg::POLY_SHIFT);
  endfunction

  function automatic logic [7:0] palette_blend(input logic [7:0] a, input logic [7:0] b,
                                               input longint unsigned num,
                                               input longint unsigned d);
    longint unsigned down;
    if (b >= a) return sat8(a + ((b - a) * num) / d);
    down = ((a - b) * num + d - 1) / d;
    return (down > a) ? 8'd0 : 8'(a - down);
  endfunction

  function automatic logic [7:0] palette_red(input longint unsigned i);
    logic [7:0] t[7] = '{252, 254, 252, 25, 22, 5, 179};
    return t[i];
  endfunction

  function automatic logic [7:0] palette_green(input longint unsigned i);
    logic [7:0] t[7] = '{0, 173, 245, 225, 166, 12, 15};
    return t[i];
  endfunction

  function automatic logic [7:0] palette_blue(input longint unsigned i);
    logic [7:0] t[7] = '{26, 41, 52, 39, 252, 193, 248};
    return t[i];
  endfunction

  function automatic color_t map_color(input sample_t s);
    color_t c;
    longint unsigned kv, kmin, kmax, d, pos, twice, mid_gap, seg, seg1, num;
    longint n, n2, one, one2;
    int comp;
    logic [7:0] pa, pb;
    kv = {32'd0, s.value ^ 32'h8000_0000};
    kmin = {32'd0, model_min ^ 32'h8000_0000};
    kmax = {32'd0, model_max ^ 32'h8000_0000};
    c = '0;
    c.invalid = (kmax <= kmin);
    if (s.not_number) begin
      c.red = 8'd255;
      c.blue = 8'd255;
    end else if (!c.invalid) begin
      if (kv < kmin) kv = kmin;
      if (kv > kmax) kv = kmax;
      d = kmax - kmin;
      pos = kv - kmin;
      if (model_scheme == scm_pkg::SCHEME_RAMP) begin
        twice = 2 * pos;
        mid_gap = (twice >= d) ? twice - d : d - twice;
        c.red = sat8((510 * pos) / d);
        c.green = 8'((255 * (d - mid_gap)) / d);
        c.blue = sat8((510 * (d - pos)) / d);
      end else if (model_scheme == scm_pkg::SCHEME_POLY) begin
        n = longint'((pos << scm_pkg::FRAC_BITS) / d);
        n2 = n * n;
        one = 64'sd1 << scm_pkg::FRAC_BITS;
        one2 = 64'sd1 << (2 * scm_pkg::FRAC_BITS);
        c.red = quad_component(-80 * n2 + 120 * n * one - 29 * one2);
        c.green = quad_component(-320 * n2 + 320 * n * one - 64 * one2);
        c.blue = quad_component(-80 * n2 + 40 * n * one + 11 * one2);
      end else begin
        seg = (pos * scm_pkg::PALETTE_ENTRIES) / d;
        if (seg > scm_pkg::PALETTE_ENTRIES - 1) seg = scm_pkg::PALETTE_ENTRIES - 1;
        seg1 = (seg + 1 > scm_pkg::PALETTE_ENTRIES - 1) ? scm_pkg::PALETTE_ENTRIES - 1
                                                         : seg + 1;
        num = pos * scm_pkg::PALETTE_ENTRIES - seg * d;
        for (comp = 0; comp < 3; comp++) begin
          case (comp)
            0: begin
              pa = palette_red(scm_pkg::PALETTE_ENTRIES - 1 - seg);
              pb = palette_red(scm_pkg::PALETTE_ENTRIES - 1 - seg1);
              c.red = palette_blend(pa, pb, num, d);
            end
            1: begin
              pa = palette_green(scm_pkg::PALETTE_ENTRIES - 1 - seg);
              pb = palette_green(scm_pkg::PALETTE_ENTRIES - 1 - seg1);
              c.green = palette_blend(pa, pb, num, d);
            end
            default: begin
              pa = palette_blue(scm_pkg::PALETTE_ENTRIES - 1 - seg);
              pb = palette_blue(scm_pkg::PALETTE_ENTRIES - 1 - seg1);
              c.blue = palette_blend(pa, pb, num, d);
            end
          endcase
        end
      end
    end
    return c;
  endfunction

  // Driver: the predictor runs when a transaction is accepted, so register
  // values always match what the block sees.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_colors.push_back(map_color('{s_axis_tdata, s_axis_tuser}));
        void'(pending_samples.pop_front());
      end
      if (!(s_axis_tvalid && !s_axis_tready)) begin
        if (s_axis_tvalid && s_axis_tready && pending_samples.size() == 0)
          s_axis_tvalid <= 1'b0;
        else if (pending_samples.size() > 0 && !hold_off &&
                 $urandom_range(99, 0) >= send_idle_pct) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= pending_samples[0].value;
          s_axis_tuser <= pending_samples[0].not_number;
        end else
          s_axis_tvalid <= 1'b0;
      end
    end
  end

  // The driver pops on acceptance, so it shows the head item; the head must be
  // the item currently on the bus when tvalid was raised.
  always @(posedge clk) begin
    if (!rst) begin
      m_axis_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_colors.size() == 0) begin
          $display("%0t: unexpected result %h/%b", $time, m_axis_tdata, m_axis_tuser);
          errors++;
        end else begin
          color_t e;
          e = expected_colors.pop_front();
          if (m_axis_tdata[7:0] !== e.red)
            $display("%0t: red expected %0d actual %0d", $time, e.red, m_axis_tdata[7:0]);
          if (m_axis_tdata[15:8] !== e.green)
            $display("%0t: green expected %0d actual %0d", $time, e.green,
                     m_axis_tdata[15:8]);
          if (m_axis_tdata[23:16] !== e.blue)
            $display("%0t: blue expected %0d actual %0d", $time, e.blue,
                     m_axis_tdata[23:16]);
          if (m_axis_tuser !== e.invalid)
            $display("%0t: range_invalid expected %b actual %b", $time, e.invalid,
                     m_axis_tuser);
          if (m_axis_tdata !== {e.blue, e.green, e.red} || m_axis_tuser !== e.invalid)
            errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == scm_pkg::REG_SCHEME) model_scheme = val[1:0];
    else if (idx == scm_pkg::REG_MIN) model_min = val;
    else if (idx == scm_pkg::REG_MAX) model_max = val;
  endtask

  task automatic drain();
    while (pending_samples.size() > 0 || s_axis_tvalid || expected_colors.size() > 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_sample(input logic [31:0] lo, input logic [31:0] hi);
    case ($urandom_range(9, 0))
      0: return $urandom;
      1: return lo;
      2: return hi;
      default: begin
        longint span;
        span = longint'($signed(hi)) - longint'($signed(lo));
        if (span <= 0) return $urandom;
        return 32'(longint'($signed(lo)) - 16 +
                   longint'({$urandom, $urandom} % (span + 33)));
      end
    endcase
  endfunction

  initial begin
    logic [31:0] lo, hi;
    int phase, k;
    errors = 0;
    quiet_cycles = 0;
    hold_off = 0;
    model_scheme = scm_pkg::SCHEME_RAMP;
    model_min = 32'd0;
    model_max = 32'd65536;
    send_idle_pct = 7;
    recv_idle_pct = 85;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // Directed part at reset settings: range ends, interior, extremes, NaN.
    pending_samples.push_back('{32'h8000_0000, 1'b0});
    pending_samples.push_back('{32'h7fff_ffff, 1'b0});
    pending_samples.push_back('{32'd0, 1'b0});
    pending_samples.push_back('{32'd65536, 1'b0});
    pending_samples.push_back('{32'd32768, 1'b0});
    pending_samples.push_back('{32'd9362, 1'b0});
    pending_samples.push_back('{32'hffff_ffff, 1'b1});
    drain();
    for (k = 0; k < 3; k++) begin
      write_reg(scm_pkg::REG_SCHEME, 32'(k));
      pending_samples.push_back('{32'd0, 1'b0});
      pending_samples.push_back('{32'd65536, 1'b0});
      pending_samples.push_back('{32'd16384, 1'b0});
      pending_samples.push_back('{32'd50000, 1'b0});
      drain();
    end
    // Selector 3 and the widest range, then an empty range with and without NaN.
    write_reg(scm_pkg::REG_SCHEME, 32'd3);
    write_reg(scm_pkg::REG_MIN, 32'h8000_0000);
    write_reg(scm_pkg::REG_MAX, 32'h7fff_ffff);
    pending_samples.push_back('{32'h8000_0000, 1'b0});
    pending_samples.push_back('{32'h7fff_ffff, 1'b0});
    pending_samples.push_back('{32'h1234_5678, 1'b0});
    drain();
    write_reg(scm_pkg::REG_MIN, 32'd100);
    write_reg(scm_pkg::REG_MAX, 32'd100);
    pending_samples.push_back('{32'd100, 1'b0});
    pending_samples.push_back('{32'd5, 1'b1});
    drain();

    for (phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 7 : (phase == 1) ? 85 : 0;
      recv_idle_pct = (phase == 0) ? 85 : (phase == 1) ? 7 : 0;
      for (k = 0; k < 13; k++) begin
        int j;
        case ($urandom_range(5, 0))
          0: begin lo = 32'h8000_0000; hi = 32'h7fff_ffff; end
          1: begin lo = $urandom; hi = $urandom; end
          2: begin lo = $urandom_range(200, 0); hi = lo + $urandom_range(20, 1); end
          default: begin
            lo = $signed($urandom_range(400000, 0)) - 200000;
            hi = lo + $urandom_range(2000000, 1);
          end
        endcase
        write_reg(scm_pkg::REG_SCHEME, $urandom_range(3, 0));
        write_reg(scm_pkg::REG_MIN, lo);
        write_reg(scm_pkg::REG_MAX, hi);
        for (j = 0; j < 50; j++)
          pending_samples.push_back('{rand_sample(lo, hi), ($urandom_range(15, 0) == 0)});
        if (k == 5) begin
          while (pending_samples.size() > 25) @(posedge clk);
          hold_off = 1;
          while (expected_colors.size() > 0 || s_axis_tvalid) @(posedge clk);
          hold_off = 0;
        end
        drain();
      end
    end

    if (errors == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
